// File: hdl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] QUOTE_CP    = 21'd34;
    localparam logic [CP_W-1:0] DELIM_RESET = 21'd44;

    // parse phase; codes 5..7 are unused and treated as discard
    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_UNQUOTED = 3'd1,
        PH_QUOTED   = 3'd2,
        PH_QSEEN    = 3'd3,
        PH_DISCARD  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2,
        KIND_FAULT     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_UNCLOSED = 2'd0,
        FAULT_TRAILING = 2'd1,
        FAULT_STRAY    = 2'd2,
        FAULT_NONE     = 2'd3
    } fault_t;

endpackage

// File: hdl/cft_char_if.sv
// ----------------------------------------------------------------------------
// cft_char_if
// Character channel: one code point or a line-end marker per transaction.
// ----------------------------------------------------------------------------
interface cft_char_if;

    logic                      valid;
    logic                      ready;
    logic [cft_pkg::CP_W-1:0]  code_point;
    logic                      line_end;

    modport source (output valid, output code_point, output line_end, input ready);
    modport sink   (input valid, input code_point, input line_end, output ready);

endinterface

// File: hdl/cft_token_if.sv
// ----------------------------------------------------------------------------
// cft_token_if
// Token channel: one field character, field end, line end or fault per
// transaction.
// ----------------------------------------------------------------------------
interface cft_token_if;

    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [cft_pkg::CP_W-1:0]  out_char;
    logic [1:0]                fault;

    modport source (output valid, output kind, output out_char, output fault, input ready);
    modport sink   (input valid, input kind, input out_char, input fault, output ready);

endinterface

// File: hdl/csv_field_tokenizer_top.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Streaming CSV/TSV field tokenizer. It takes one character transaction per
// clock unless the token output stalls and turns it into at most one token:
// a field character, a field end, a field end that also closes the line, or
// a fault (unclosed quote, text after a closing quote, quote inside an
// unquoted field). A quoted field keeps delimiters literally and turns a
// doubled quote into one quote. After a fault the rest of the line is dropped
// and the line end restarts parsing silently. Throughput is one character per
// cycle with no bubbles while token_out.ready holds; a token passes the input
// register, the parse logic and the token register. Characters that produce
// no token (opening/closing quote, discarded text) are simply consumed. The
// delimiter register resets to comma. The user must write it through cfg_we/
// cfg_wdata only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cft_pkg::CP_W-1:0]  cfg_wdata,
    cft_char_if.sink                  char_in,
    cft_token_if.source               token_out
);

    // delimiter register
    logic [cft_pkg::CP_W-1:0] delim_reg;

    // input stage
    logic                     in_valid_reg;
    logic [cft_pkg::CP_W-1:0] in_cp_reg;
    logic                     in_eol_reg;

    // parse state
    cft_pkg::phase_t phase_reg;
    cft_pkg::phase_t phase_next;

    // token stage
    logic                     out_valid_reg;
    cft_pkg::kind_t           kind_reg;
    logic [cft_pkg::CP_W-1:0] char_reg;
    cft_pkg::fault_t          fault_reg;

    // result of the parse logic for the item in the input stage
    logic                     res_valid;
    cft_pkg::kind_t           res_kind;
    logic [cft_pkg::CP_W-1:0] res_char;
    cft_pkg::fault_t          res_fault;

    logic out_free;   // token register can take a new token this cycle
    logic advance;    // input stage item is processed this cycle
    logic in_take;    // character transaction accepted

    logic is_quote;
    logic is_delim;

    assign out_free = !out_valid_reg || token_out.ready;
    assign advance  = in_valid_reg && out_free;
    assign char_in.ready = !in_valid_reg || out_free;
    assign in_take  = char_in.valid && char_in.ready;

    assign is_quote = (in_cp_reg == cft_pkg::QUOTE_CP);
    assign is_delim = (in_cp_reg == delim_reg);

    // ------------------------------------------------------------------
    // Parse logic: one phase transition per character. Quote test comes
    // ahead of the delimiter test at field start and after a quote; in an
    // unquoted field the delimiter wins.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        res_valid  = 1'b0;
        res_kind   = cft_pkg::KIND_CHAR;
        res_char   = '0;
        res_fault  = cft_pkg::FAULT_UNCLOSED;
        case (phase_reg)
            cft_pkg::PH_START:
            begin
                if (in_eol_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_LINE_END;
                end
                else if (is_quote)
                begin
                    phase_next = cft_pkg::PH_QUOTED;
                end
                else if (is_delim)
                begin
                    res_valid = 1'b1;
                    res_kind  = cft_pkg::KIND_FIELD_END;
                end
                else
                begin
                    phase_next = cft_pkg::PH_UNQUOTED;
                    res_valid  = 1'b1;
                    res_char   = in_cp_reg;
                end
            end
            cft_pkg::PH_UNQUOTED:
            begin
                if (in_eol_reg)
                begin
                    phase_next = cft_pkg::PH_START;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_LINE_END;
                end
                else if (is_delim)
                begin
                    phase_next = cft_pkg::PH_START;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_FIELD_END;
                end
                else if (is_quote)
                begin
                    // stray quote inside an unquoted field
                    phase_next = cft_pkg::PH_DISCARD;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_FAULT;
                    res_fault  = cft_pkg::FAULT_STRAY;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_char  = in_cp_reg;
                end
            end
            cft_pkg::PH_QUOTED:
            begin
                if (in_eol_reg)
                begin
                    // unclosed quote; no line-end token follows
                    phase_next = cft_pkg::PH_START;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_FAULT;
                    res_fault  = cft_pkg::FAULT_UNCLOSED;
                end
                else if (is_quote)
                begin
                    phase_next = cft_pkg::PH_QSEEN;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_char  = in_cp_reg;
                end
            end
            cft_pkg::PH_QSEEN:
            begin
                if (in_eol_reg)
                begin
                    phase_next = cft_pkg::PH_START;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_LINE_END;
                end
                else if (is_quote)
                begin
                    // doubled quote gives one literal quote
                    phase_next = cft_pkg::PH_QUOTED;
                    res_valid  = 1'b1;
                    res_char   = cft_pkg::QUOTE_CP;
                end
                else if (is_delim)
                begin
                    phase_next = cft_pkg::PH_START;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_FIELD_END;
                end
                else
                begin
                    // text after the closing quote
                    phase_next = cft_pkg::PH_DISCARD;
                    res_valid  = 1'b1;
                    res_kind   = cft_pkg::KIND_FAULT;
                    res_fault  = cft_pkg::FAULT_TRAILING;
                end
            end
            default:
            begin
                // discard until line end
                if (in_eol_reg)
                    phase_next = cft_pkg::PH_START;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= cft_pkg::DELIM_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= cft_pkg::PH_START;
        end
        else
        begin
            if (cfg_we)
                delim_reg <= cfg_wdata;
            if (char_in.ready)
                in_valid_reg <= char_in.valid;
            if (advance)
                phase_reg <= phase_next;
            if (out_free)
                out_valid_reg <= advance && res_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cp_reg  <= char_in.code_point;
            in_eol_reg <= char_in.line_end;
        end
        if (advance && res_valid)
        begin
            kind_reg  <= res_kind;
            char_reg  <= res_char;
            fault_reg <= (res_kind == cft_pkg::KIND_FAULT) ? res_fault
                                                           : cft_pkg::FAULT_UNCLOSED;
        end
    end

    assign token_out.valid    = out_valid_reg;
    assign token_out.kind     = kind_reg;
    assign token_out.out_char = char_reg;
    assign token_out.fault    = fault_reg;

endmodule
